FILE: hw/rtl/pwrcd_pkg.sv
// ----------------------------------------------------------------------------
// pwrcd_pkg
// Shared types and constants of the pulse width remote code decoder.
// ----------------------------------------------------------------------------
package pwrcd_pkg;

  // Sample duration width, two's complement
  localparam int DURATION_WIDTH = 24;
  localparam int MAX_CODE_BITS  = 32;

  // Magnitude must hold the widest of duration and 16-bit targets
  localparam int MAG_W   = (DURATION_WIDTH > 16) ? DURATION_WIDTH : 16;
  localparam int TOL_W   = 7;
  localparam int DUR_CFG_W = 16;
  localparam int PROD_W  = DUR_CFG_W + TOL_W;
  localparam int CMP_W   = MAG_W + TOL_W;
  localparam int PERCENT = 100;

  localparam int CODE_W     = 32;
  localparam int CODE_LEN_W = 6;
  localparam int COUNT_W    = 16;

  // Stream widths, rounded up to whole bytes
  localparam int TDATA_IN_W  = ((DURATION_WIDTH + 7) / 8) * 8;
  localparam int OUT_FIELD_W = CODE_W + CODE_LEN_W;
  localparam int TDATA_OUT_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = TDATA_OUT_W - OUT_FIELD_W;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SHORT_DUR   = 3'd0,
    CFG_LONG_DUR    = 3'd1,
    CFG_TOLERANCE   = 3'd2,
    CFG_CODE_BITS   = 3'd3,
    CFG_MIN_STOP    = 3'd4,
    CFG_MIN_SAMPLES = 3'd5
  } cfg_idx_e;

  localparam logic [DUR_CFG_W-1:0]  RST_SHORT_DUR   = 16'd430;
  localparam logic [DUR_CFG_W-1:0]  RST_LONG_DUR    = 16'd870;
  localparam logic [TOL_W-1:0]      RST_TOLERANCE   = 7'd40;
  localparam logic [CODE_LEN_W-1:0] RST_CODE_BITS   = 6'd9;
  localparam logic [CODE_LEN_W-1:0] RST_MIN_STOP    = 6'd7;
  localparam logic [COUNT_W-1:0]    RST_MIN_SAMPLES = 16'd16;

  // Queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  typedef struct packed {
    logic [DUR_CFG_W-1:0]  short_dur;
    logic [DUR_CFG_W-1:0]  long_dur;
    logic [TOL_W-1:0]      tol;
    logic [CODE_LEN_W-1:0] code_bits;
    logic [CODE_LEN_W-1:0] min_stop;
    logic [COUNT_W-1:0]    min_samples;
  } cfg_t;

  // Classified sample handed from front to back
  typedef struct packed {
    logic neg;
    logic last;
    logic is_short;
    logic is_long;
  } entry_t;

  typedef struct packed {
    logic                  decoded;
    logic [CODE_W-1:0]     code_value;
    logic [CODE_LEN_W-1:0] code_length;
  } result_t;

endpackage

FILE: hw/rtl/pulse_width_remote_code_decoder.sv
// ----------------------------------------------------------------------------
// pulse_width_remote_code_decoder
// Decodes on-off keyed remote codes from a stream of signed pulse durations.
// ----------------------------------------------------------------------------
// Samples arrive on the slave stream as signed durations (positive high,
// negative low), tlast marking the last sample of a frame; exactly one
// result request leaves on the master stream for each frame, on its last
// sample. A new sample is taken every cycle while the queue has room: the front
// classifies it in one register stage, a four-entry queue decouples it from
// the back, and the back pairs pulse and gap into bits and holds the result
// in an output register, so a stalled result does not stop the front until
// the queue fills. A last sample passes the front register, queue and output
// register. Pulse/gap matching is |d - t| * 100 <= t * tolerance on the
// magnitude. Short pulse with long gap is bit 0, long pulse with short gap is
// bit 1, shifted in MSB first. A leading low sample is skipped; a low in a
// pulse position fails the frame; an unmatched pair clears the code, or
// fails the frame once min_bits_before_stop bits are held. A frame with
// fewer than min_frame_samples samples never reports a code. Configuration
// (indexes 0..5: short, long, tolerance, code bits, min bits before stop,
// min frame samples) must be written only while the block is idle (not enforced).
// ----------------------------------------------------------------------------
module pulse_width_remote_code_decoder (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Configuration writes
  input  logic                                  cfg_we_i,
  input  logic [pwrcd_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [pwrcd_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  // Sample stream
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [pwrcd_pkg::TDATA_IN_W-1:0]      s_axis_tdata,  // duration
  input  logic                                  s_axis_tlast,
  // Result stream
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [pwrcd_pkg::TDATA_OUT_W-1:0]     m_axis_tdata,  // code_value, code_length
  output logic                                  m_axis_tuser   // decoded
);
  import pwrcd_pkg::*;

  cfg_t    cfg_q;
  entry_t  fr_entry, fifo_entry;
  logic    fr_valid, fr_ready, fifo_valid, fifo_ready;
  result_t res;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.short_dur   <= RST_SHORT_DUR;
      cfg_q.long_dur    <= RST_LONG_DUR;
      cfg_q.tol         <= RST_TOLERANCE;
      cfg_q.code_bits   <= RST_CODE_BITS;
      cfg_q.min_stop    <= RST_MIN_STOP;
      cfg_q.min_samples <= RST_MIN_SAMPLES;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_SHORT_DUR:   cfg_q.short_dur   <= cfg_wdata_i[DUR_CFG_W-1:0];
        CFG_LONG_DUR:    cfg_q.long_dur    <= cfg_wdata_i[DUR_CFG_W-1:0];
        CFG_TOLERANCE:   cfg_q.tol         <= cfg_wdata_i[TOL_W-1:0];
        CFG_CODE_BITS:   cfg_q.code_bits   <= cfg_wdata_i[CODE_LEN_W-1:0];
        CFG_MIN_STOP:    cfg_q.min_stop    <= cfg_wdata_i[CODE_LEN_W-1:0];
        CFG_MIN_SAMPLES: cfg_q.min_samples <= cfg_wdata_i[COUNT_W-1:0];
        default: ;  // unused indexes are ignored
      endcase
    end
  end

  pwrcd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .duration_i  (s_axis_tdata[DURATION_WIDTH-1:0]),
    .last_i      (s_axis_tlast),
    .out_valid_o (fr_valid),
    .out_ready_i (fr_ready),
    .out_o       (fr_entry)
  );

  pwrcd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_data_i  (fr_entry),
    .pop_valid_o  (fifo_valid),
    .pop_ready_i  (fifo_ready),
    .pop_data_o   (fifo_entry)
  );

  pwrcd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (fifo_valid),
    .in_ready_o  (fifo_ready),
    .in_i        (fifo_entry),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, res.code_length, res.code_value};
  assign m_axis_tuser = res.decoded;

  // A failed frame reports all-zero code fields
  a_fail_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("failed frame with non-zero code fields");

  // A decoded code has a length between one and the code register width
  a_len_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |->
      (res.code_length != '0 && res.code_length <= CODE_LEN_W'(MAX_CODE_BITS)))
    else $error("decoded code length out of range");

  // The queue drains a last sample only while the output register can take it
  a_last_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fifo_valid && fifo_ready && fifo_entry.last && m_axis_tvalid) |-> m_axis_tready)
    else $error("result overwritten before delivery");

endmodule

FILE: hw/rtl/pwrcd_front.sv
// ----------------------------------------------------------------------------
// pwrcd_front
// Takes samples, forms magnitude distances to both nominal durations and
// classifies them as short and/or long within tolerance.
// ----------------------------------------------------------------------------
module pwrcd_front (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  pwrcd_pkg::cfg_t                         cfg_i,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic [pwrcd_pkg::DURATION_WIDTH-1:0]    duration_i,
  input  logic                                    last_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output pwrcd_pkg::entry_t                       out_o
);
  import pwrcd_pkg::*;

  logic                      neg;
  logic [DURATION_WIDTH-1:0] mag_raw;
  logic [MAG_W-1:0]          mag, tgt_s, tgt_l, diff_s, diff_l;

  logic                      v_q, neg_q, last_q;
  logic [MAG_W-1:0]          diff_s_q, diff_l_q;

  logic [CMP_W-1:0]          lhs_s, lhs_l;
  logic [PROD_W-1:0]         rhs_s, rhs_l;

  // Stage 1: magnitude and distances
  assign neg     = duration_i[DURATION_WIDTH-1];
  assign mag_raw = neg ? (~duration_i + DURATION_WIDTH'(1)) : duration_i;
  assign mag     = MAG_W'(mag_raw);
  assign tgt_s   = MAG_W'(cfg_i.short_dur);
  assign tgt_l   = MAG_W'(cfg_i.long_dur);
  assign diff_s  = (mag >= tgt_s) ? (mag - tgt_s) : (tgt_s - mag);
  assign diff_l  = (mag >= tgt_l) ? (mag - tgt_l) : (tgt_l - mag);

  assign in_ready_o = !v_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (in_ready_o) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      diff_s_q <= diff_s;
      diff_l_q <= diff_l;
      neg_q    <= neg;
      last_q   <= last_i;
    end
  end

  // Stage 2: |m - t| * 100 <= t * tol
  assign lhs_s = CMP_W'(diff_s_q) * CMP_W'(PERCENT);
  assign lhs_l = CMP_W'(diff_l_q) * CMP_W'(PERCENT);
  assign rhs_s = PROD_W'(cfg_i.short_dur) * PROD_W'(cfg_i.tol);
  assign rhs_l = PROD_W'(cfg_i.long_dur) * PROD_W'(cfg_i.tol);

  assign out_valid_o    = v_q;
  assign out_o.neg      = neg_q;
  assign out_o.last     = last_q;
  assign out_o.is_short = lhs_s <= CMP_W'(rhs_s);
  assign out_o.is_long  = lhs_l <= CMP_W'(rhs_l);

endmodule

FILE: hw/rtl/pwrcd_fifo.sv
// ----------------------------------------------------------------------------
// pwrcd_fifo
// Short queue of classified samples between front and back.
// ----------------------------------------------------------------------------
module pwrcd_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  pwrcd_pkg::entry_t push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output pwrcd_pkg::entry_t pop_data_o
);
  import pwrcd_pkg::*;

  entry_t                 mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0]  cnt_q;
  logic                   push, pop;

  assign push_ready_o = cnt_q != FIFO_CNT_W'(FIFO_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
      if (pop)  rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + FIFO_CNT_W'(1);
        2'b01:   cnt_q <= cnt_q - FIFO_CNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

FILE: hw/rtl/pwrcd_back.sv
// ----------------------------------------------------------------------------
// pwrcd_back
// Pairs pulse and gap classes into bits, tracks the frame outcome and
// registers one result per frame.
// ----------------------------------------------------------------------------
module pwrcd_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pwrcd_pkg::cfg_t    cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  pwrcd_pkg::entry_t  in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output pwrcd_pkg::result_t out_o
);
  import pwrcd_pkg::*;

  typedef enum logic [1:0] {
    OUT_SEARCHING = 2'd0,
    OUT_SUCCESS   = 2'd1,
    OUT_FAILED    = 2'd2
  } outcome_e;

  logic [COUNT_W-1:0]    cnt_q, cnt_d;
  logic                  phase_q, phase_d;
  logic [1:0]            held_q, held_d;
  logic [CODE_W-1:0]     shift_q, shift_d;
  logic [CODE_LEN_W-1:0] nbits_q, nbits_d;
  outcome_e              outcome_q, outcome_d;
  logic                  out_v_q, out_v_d;
  result_t               res_q, res_d;

  logic                  out_free, take;

  assign out_free   = !out_v_q || out_ready_i;
  assign in_ready_o = !in_i.last || out_free;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    logic                  first;
    logic [CODE_LEN_W-1:0] target;
    logic [COUNT_W-1:0]    cnt_n;
    logic                  phase_n;
    logic [1:0]            held_n;
    logic [CODE_W-1:0]     shift_n;
    logic [CODE_LEN_W-1:0] nbits_n;
    outcome_e              outcome_n;
    logic                  bit0, bit1, ok;

    cnt_d     = cnt_q;
    phase_d   = phase_q;
    held_d    = held_q;
    shift_d   = shift_q;
    nbits_d   = nbits_q;
    outcome_d = outcome_q;
    out_v_d   = out_v_q && !out_ready_i;
    res_d     = res_q;

    first     = cnt_q == '0;
    target    = (cfg_i.code_bits > CODE_LEN_W'(MAX_CODE_BITS)) ?
                CODE_LEN_W'(MAX_CODE_BITS) : cfg_i.code_bits;
    cnt_n     = (cnt_q != '1) ? cnt_q + COUNT_W'(1) : cnt_q;
    phase_n   = phase_q;
    held_n    = held_q;
    shift_n   = shift_q;
    nbits_n   = nbits_q;
    outcome_n = outcome_q;
    bit0      = held_q[0] && in_i.is_long;
    bit1      = held_q[1] && in_i.is_short;

    // A leading low sample is skipped
    if (outcome_q == OUT_SEARCHING && !(first && in_i.neg)) begin
      if (!phase_q) begin
        if (in_i.neg) begin
          outcome_n = OUT_FAILED;
        end else begin
          held_n  = {in_i.is_long, in_i.is_short};
          phase_n = 1'b1;
        end
      end else begin
        phase_n = 1'b0;
        if (bit0 || bit1) begin
          shift_n = {shift_q[CODE_W-2:0], !bit0};
          if (nbits_q != '1) nbits_n = nbits_q + CODE_LEN_W'(1);
          if (nbits_n == target) outcome_n = OUT_SUCCESS;
        end else if (nbits_q >= cfg_i.min_stop) begin
          outcome_n = OUT_FAILED;
        end else begin
          shift_n = '0;
          nbits_n = '0;
        end
      end
    end

    ok = (outcome_n == OUT_SUCCESS) && (cnt_n >= cfg_i.min_samples);

    if (take) begin
      if (in_i.last) begin
        out_v_d           = 1'b1;
        res_d.decoded     = ok;
        res_d.code_value  = ok ? shift_n : '0;
        res_d.code_length = ok ? nbits_n : '0;
        cnt_d     = '0;
        phase_d   = 1'b0;
        held_d    = '0;
        shift_d   = '0;
        nbits_d   = '0;
        outcome_d = OUT_SEARCHING;
      end else begin
        cnt_d     = cnt_n;
        phase_d   = phase_n;
        held_d    = held_n;
        shift_d   = shift_n;
        nbits_d   = nbits_n;
        outcome_d = outcome_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      phase_q   <= 1'b0;
      held_q    <= '0;
      shift_q   <= '0;
      nbits_q   <= '0;
      outcome_q <= OUT_SEARCHING;
      out_v_q   <= 1'b0;
      res_q     <= '0;
    end else begin
      cnt_q     <= cnt_d;
      phase_q   <= phase_d;
      held_q    <= held_d;
      shift_q   <= shift_d;
      nbits_q   <= nbits_d;
      outcome_q <= outcome_d;
      out_v_q   <= out_v_d;
      res_q     <= res_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_o       = res_q;

endmodule
